>>> rtl/core/kce_pkg.sv
// ----------------------------------------------------------------------------
// kce_pkg: shared types and constants of the k-combination enumerator
// Field widths, operation codes, register indexes, and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kce_pkg;

  // Fixed field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned POS_OUT_W = 3;
  localparam int unsigned SET_W     = 7;
  localparam int unsigned PICK_W    = 4;
  // Chosen positions stay below set_size, so they fit the set_size width
  localparam int unsigned POS_W     = SET_W;

  // Default module parameters
  localparam int unsigned DEF_MAX_ITEMS     = 64;
  localparam int unsigned DEF_MAX_PICK      = 8;
  localparam int unsigned DEF_ELEMENT_WIDTH = 32;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_SET_SIZE  = 1'b0;
  localparam logic        REG_PICK_SIZE = 1'b1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT    = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] value;
  } kce_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] element;
    logic [POS_OUT_W-1:0]      position;
    logic                      last_of_selection;
    logic                      exhausted;
  } kce_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;         // write the input element into the store
    logic restart;      // positions back to 0..k-1, set first, clear done
    logic next_first;   // first selection: clear first flag, start emission
    logic search_init;  // carry search starts at position k-1
    logic search_step;  // move the carry search one position left
    logic bump;         // bump the searched position, refill, start emission
    logic set_done;     // no selection remains
    logic rd_issue;     // read the store at the current emitted position
    logic out_load;     // load the output register with the read element
    logic emit_next;    // advance to the next position of the selection
    logic out_exh;      // load the output register with the exhausted result
  } kce_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
    logic k_bad;
    logic first;
    logic found;
    logic p_zero;
    logic i_last;
    logic out_free;
  } kce_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/k_combination_enumerator_unit.sv
// ----------------------------------------------------------------------------
// k_combination_enumerator_unit: k-combination enumerator, top level
// Loads a store of signed elements and emits every k-element selection of
// the first n entries in lexicographic order of positions.
//
//   Channel   Direction  Handshake         Payload
//   in        sink       in_valid/ready    kce_in_t  (operation, slot, value)
//   out       source     out_valid/ready   kce_out_t (element, position, flags)
//   cfg       APB slave  psel/penable      set_size @0x0, pick_size @0x4
//
// Load, restart and unknown items finish in the idle state; an exhausted answer
// passes through the exhausted state. A next item runs a carry search over up
// to k positions, one position a cycle, then a read and a write step per element.
// A stalled output holds the sequencer in its emit step; input waits meanwhile.
// Reset restores positions 0..k-1, n = k = 1; the store holds no reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module k_combination_enumerator_unit #(
  parameter int unsigned MAX_ITEMS     = kce_pkg::DEF_MAX_ITEMS,
  parameter int unsigned MAX_PICK      = kce_pkg::DEF_MAX_PICK,
  parameter int unsigned ELEMENT_WIDTH = kce_pkg::DEF_ELEMENT_WIDTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire kce_pkg::kce_in_t                 in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output kce_pkg::kce_out_t                     out_data_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [kce_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [kce_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [kce_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  import kce_pkg::*;

  logic              cfg_we;
  logic [SET_W-1:0]  set_size_q;
  logic [PICK_W-1:0] pick_size_q;
  kce_cmd_t          cmd;
  kce_sts_t          sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q  <= SET_W'(1);
      pick_size_q <= PICK_W'(1);
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_SET_SIZE:  set_size_q  <= pwdata[SET_W-1:0];
        REG_PICK_SIZE: pick_size_q <= pwdata[PICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SET_SIZE:  prdata = APB_DATA_W'(set_size_q);
      REG_PICK_SIZE: prdata = APB_DATA_W'(pick_size_q);
      default:       prdata = '0;
    endcase
  end

  kce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (in_data_i.operation),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kce_dp #(
    .MAX_ITEMS     (MAX_ITEMS),
    .MAX_PICK      (MAX_PICK),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_data_i     (in_data_i),
    .cfg_restart_i (cfg_we),
    .set_size_i    (set_size_q),
    .pick_size_i   (pick_size_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/kce_ram.sv
// ----------------------------------------------------------------------------
// kce_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds while
// no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module kce_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/kce_ctrl.sv
// ----------------------------------------------------------------------------
// kce_ctrl: controller of the k-combination enumerator
// Decodes accepted items and sequences the carry search and the emission of
// one selection, one element at a time, through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module kce_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [kce_pkg::OP_W-1:0]    op_i,
  input  wire kce_pkg::kce_sts_t           sts_i,
  output kce_pkg::kce_cmd_t                cmd_o
);

  import kce_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_RD     = 3'd2;
  localparam logic [2:0] ST_WR     = 3'd3;
  localparam logic [2:0] ST_EXH    = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            OP_LOAD:    cmd_o.load = 1'b1;
            OP_RESTART: cmd_o.restart = 1'b1;
            OP_NEXT: begin
              priority if (sts_i.done) begin
                state_d = ST_EXH;
              end else if (sts_i.k_bad) begin
                cmd_o.set_done = 1'b1;
                state_d        = ST_EXH;
              end else if (sts_i.first) begin
                cmd_o.next_first = 1'b1;
                state_d          = ST_RD;
              end else begin
                cmd_o.search_init = 1'b1;
                state_d           = ST_SEARCH;
              end
            end
            default: ;  // unknown operation: drop
          endcase
        end
      end
      ST_SEARCH: begin
        priority if (sts_i.found) begin
          cmd_o.bump = 1'b1;
          state_d    = ST_RD;
        end else if (sts_i.p_zero) begin
          cmd_o.set_done = 1'b1;
          state_d        = ST_EXH;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_WR;
      end
      ST_WR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.i_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = ST_RD;
          end
        end
      end
      ST_EXH: begin
        if (sts_i.out_free) begin
          cmd_o.out_exh = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/kce_dp.sv
// ----------------------------------------------------------------------------
// kce_dp: datapath of the k-combination enumerator
// Element store, chosen positions with the carry search and refill, the
// enumeration flags and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kce_dp #(
  parameter int unsigned MAX_ITEMS     = kce_pkg::DEF_MAX_ITEMS,
  parameter int unsigned MAX_PICK      = kce_pkg::DEF_MAX_PICK,
  parameter int unsigned ELEMENT_WIDTH = kce_pkg::DEF_ELEMENT_WIDTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire kce_pkg::kce_cmd_t           cmd_i,
  output kce_pkg::kce_sts_t                sts_o,
  input  wire kce_pkg::kce_in_t            in_data_i,
  input  wire logic                        cfg_restart_i,
  input  wire logic [kce_pkg::SET_W-1:0]   set_size_i,
  input  wire logic [kce_pkg::PICK_W-1:0]  pick_size_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output kce_pkg::kce_out_t                out_data_o
);

  import kce_pkg::*;

  localparam int unsigned AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned PIW = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
  localparam int unsigned KW  = PICK_W + 1;
  localparam int unsigned CW  = SET_W + 1;

  logic [SET_W-1:0]  n_eff;
  logic [PICK_W-1:0] k_eff;

  logic [POS_W-1:0] pos_q [MAX_PICK];
  logic [POS_W-1:0] pos_d [MAX_PICK];
  logic [PIW-1:0]   p_q, p_d;
  logic [PIW-1:0]   i_q, i_d;
  logic             first_q, first_d;
  logic             done_q, done_d;
  logic             out_valid_q, out_valid_d;
  kce_out_t         out_data_q, out_data_d;

  logic [PIW-1:0]           rd_idx;
  logic [POS_W-1:0]         pos_rd;
  logic [POS_W-1:0]         bump_val;
  logic [CW-1:0]            ceil_val;
  logic                     slot_ok;
  logic [ELEMENT_WIDTH-1:0] ram_rdata;

  // Saturate the configured sizes to the built store and position depths
  always_comb begin
    n_eff = (int'(set_size_i) > MAX_ITEMS) ? SET_W'(MAX_ITEMS) : set_size_i;
    k_eff = (int'(pick_size_i) > MAX_PICK) ? PICK_W'(MAX_PICK) : pick_size_i;
  end

  // One read port on the positions: emission uses i, the carry search uses p
  assign rd_idx   = cmd_i.rd_issue ? i_q : p_q;
  assign pos_rd   = pos_q[rd_idx];
  assign bump_val = pos_rd + POS_W'(1);
  assign ceil_val = CW'(n_eff) - CW'(k_eff) + CW'(p_q);
  assign slot_ok  = int'(in_data_i.slot) < MAX_ITEMS;

  assign sts_o.done     = done_q;
  assign sts_o.k_bad    = (k_eff == '0) || (SET_W'(k_eff) > n_eff);
  assign sts_o.first    = first_q;
  assign sts_o.found    = CW'(pos_rd) < ceil_val;
  assign sts_o.p_zero   = (p_q == '0);
  assign sts_o.i_last   = (KW'(i_q) + KW'(1)) == KW'(k_eff);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    pos_d   = pos_q;
    p_d     = p_q;
    i_d     = i_q;
    first_d = first_q;
    done_d  = done_q;
    if (cmd_i.restart || cfg_restart_i) begin
      for (int j = 0; j < MAX_PICK; j++) begin
        pos_d[j] = POS_W'(j);
      end
      first_d = 1'b1;
      done_d  = 1'b0;
    end
    if (cmd_i.set_done) begin
      done_d = 1'b1;
    end
    if (cmd_i.next_first) begin
      first_d = 1'b0;
      i_d     = '0;
    end
    if (cmd_i.search_init) begin
      p_d = PIW'(k_eff - PICK_W'(1));
    end
    if (cmd_i.search_step) begin
      p_d = p_q - PIW'(1);
    end
    if (cmd_i.bump) begin
      // Bump position p, refill everything right of it consecutively
      for (int j = 0; j < MAX_PICK; j++) begin
        if (PIW'(j) == p_q) begin
          pos_d[j] = bump_val;
        end else if ((PIW'(j) > p_q) && (KW'(j) < KW'(k_eff))) begin
          pos_d[j] = bump_val + POS_W'(j) - POS_W'(p_q);
        end
      end
      i_d = '0;
    end
    if (cmd_i.emit_next) begin
      i_d = i_q + PIW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (cmd_i.out_load) begin
      out_valid_d                  = 1'b1;
      out_data_d.element           = $signed(VALUE_W'(ram_rdata));
      out_data_d.position          = POS_OUT_W'(i_q);
      out_data_d.last_of_selection = sts_o.i_last;
      out_data_d.exhausted         = 1'b0;
    end else if (cmd_i.out_exh) begin
      out_valid_d                  = 1'b1;
      out_data_d.element           = '0;
      out_data_d.position          = '0;
      out_data_d.last_of_selection = 1'b1;
      out_data_d.exhausted         = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_PICK; j++) begin
        pos_q[j] <= POS_W'(j);
      end
      p_q         <= '0;
      i_q         <= '0;
      first_q     <= 1'b1;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      p_q         <= p_d;
      i_q         <= i_d;
      first_q     <= first_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  kce_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && slot_ok),
    .waddr_i (AW'(in_data_i.slot)),
    .wdata_i (ELEMENT_WIDTH'($unsigned(in_data_i.value))),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (AW'(pos_rd)),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTH
  a_exh_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.exhausted |->
      out_data_o.last_of_selection && (out_data_o.element == '0))
    else $error("exhausted result without last flag or with nonzero element");

  a_bump_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bump |-> !done_q && !first_q)
    else $error("carry bump while done or before first selection");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (KW'(i_q) < KW'(k_eff)))
    else $error("emitted index beyond pick size");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !$past(done_q) |-> $past(cmd_i.set_done))
    else $error("done flag set without a done command");
`endif

endmodule

`default_nettype wire
